/* sv/cc20_pkg.sv */
// cc20_pkg: shared types, constants and helpers for the ChaCha20 keystream block.
// No dependencies; every other file of the block depends on it.
package cc20_pkg;

  localparam int WORD_W         = 32;
  localparam int NUM_WORDS      = 16;
  localparam int WORD_IDX_W     = $clog2(NUM_WORDS);
  localparam int LANES          = 4;
  localparam int COUNTER_WORD   = 12;
  localparam int CFG_WORDS      = NUM_WORDS - 1;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_WIDE_REGS  = 7;
  localparam int DOUBLE_ROUNDS  = 10;
  localparam int PHASE_W        = 2;
  localparam int STEPS_PER_DR   = 2 * (2 ** PHASE_W);

  localparam int ROT_A16 = 16;
  localparam int ROT_C12 = 12;
  localparam int ROT_A8  = 8;
  localparam int ROT_C7  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CONST_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // one line of a quarter-round: add, xor, rotate
  typedef enum logic [PHASE_W-1:0] {
    PH_A16,
    PH_C12,
    PH_A8,
    PH_C7
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_t phase;
    logic   diag;
    logic   finalize;
    logic   shift;
  } ctrl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

/* sv/cc20_if.sv */
// cc20_ctr_if / cc20_ks_if: valid/ready channels of the ChaCha20 keystream block.
// Depends on cc20_pkg for field widths.
interface cc20_ctr_if;
  logic                       valid;
  logic                       ready;
  logic [cc20_pkg::WORD_W-1:0] block_counter;

  modport source (output valid, block_counter, input ready);
  modport sink   (input valid, block_counter, output ready);
endinterface

interface cc20_ks_if;
  logic                           valid;
  logic                           ready;
  logic [cc20_pkg::WORD_IDX_W-1:0] word_index;
  logic [cc20_pkg::WORD_W-1:0]     keystream_word;
  logic                           last_word;

  modport source (output valid, word_index, keystream_word, last_word, input ready);
  modport sink   (input valid, word_index, keystream_word, last_word, output ready);
endinterface

/* sv/cc20_cfg.sv */
// cc20_cfg: configuration registers (constant, key, nonce) and their state-word view.
// Depends on cc20_pkg.
module cc20_cfg (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]                 cfg_data,
  output logic [cc20_pkg::CFG_WORDS-1:0][cc20_pkg::WORD_W-1:0] cfg_words
);
  import cc20_pkg::*;

  logic [CFG_DATA_W-1:0] wide_regs [NUM_WIDE_REGS];
  logic [WORD_W-1:0]     nonce_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WIDE_REGS; i++) begin
        wide_regs[i] <= '0;
      end
      nonce_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NONCE_HIGH: begin
          nonce_high <= cfg_data[WORD_W-1:0];
        end
        default: begin
          wide_regs[cfg_index] <= cfg_data;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WIDE_REGS; i++) begin
      cfg_words[2*i]   = wide_regs[i][WORD_W-1:0];
      cfg_words[2*i+1] = wide_regs[i][2*WORD_W-1:WORD_W];
    end
    cfg_words[CFG_WORDS-1] = nonce_high;
  end

endmodule

/* sv/cc20_lane.sv */
// cc20_lane: one quarter-round lane; applies one add/xor/rotate line per cycle.
// Depends on cc20_pkg.
module cc20_lane (
  input  cc20_pkg::phase_t              phase,
  input  logic [cc20_pkg::WORD_W-1:0]   a,
  input  logic [cc20_pkg::WORD_W-1:0]   b,
  input  logic [cc20_pkg::WORD_W-1:0]   c,
  input  logic [cc20_pkg::WORD_W-1:0]   d,
  output logic [cc20_pkg::WORD_W-1:0]   qa,
  output logic [cc20_pkg::WORD_W-1:0]   qb,
  output logic [cc20_pkg::WORD_W-1:0]   qc,
  output logic [cc20_pkg::WORD_W-1:0]   qd
);
  import cc20_pkg::*;

  logic              c_line;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] rot;

  assign c_line = (phase == PH_C12) || (phase == PH_C7);
  assign sum    = c_line ? (c + d) : (a + b);
  assign mixed  = c_line ? (b ^ sum) : (d ^ sum);

  always_comb begin
    case (phase)
      PH_A16:  rot = rotl(mixed, ROT_A16);
      PH_C12:  rot = rotl(mixed, ROT_C12);
      PH_A8:   rot = rotl(mixed, ROT_A8);
      PH_C7:   rot = rotl(mixed, ROT_C7);
      default: rot = mixed;
    endcase
  end

  always_comb begin
    qa = a;
    qb = b;
    qc = c;
    qd = d;
    if (c_line) begin
      qc = sum;
      qb = rot;
    end else begin
      qa = sum;
      qd = rot;
    end
  end

endmodule

/* sv/cc20_seq.sv */
// cc20_seq: block sequencer; load, round steps, final add and word emission.
// Depends on cc20_pkg.
module cc20_seq #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              out_ready,
  output logic                              in_ready,
  output logic                              out_valid,
  output logic [cc20_pkg::WORD_IDX_W-1:0]   word_index,
  output logic                              last_word,
  output cc20_pkg::ctrl_t                   ctrl
);
  import cc20_pkg::*;

  localparam int ROUND_STEPS = DOUBLE_ROUNDS * STEPS_PER_DR;
  localparam int STEP_W      = $clog2(ROUND_STEPS);

  state_t                state;
  state_t                state_next;
  logic [STEP_W-1:0]     step;
  logic [WORD_IDX_W-1:0] emit_idx;
  logic                  step_last;
  logic                  emit_last;

  assign step_last = (step == STEP_W'(ROUND_STEPS - 1));
  assign emit_last = (emit_idx == WORD_IDX_W'(NUM_WORDS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ROUND;
      ST_ROUND: if (step_last) state_next = ST_FINAL;
      ST_FINAL: state_next = ST_EMIT;
      ST_EMIT:  if (out_ready && emit_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.phase    = phase_t'(step[PHASE_W-1:0]);
    ctrl.diag     = step[PHASE_W];
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
      end
      ST_FINAL: begin
        ctrl.finalize = 1'b1;
      end
      ST_EMIT: begin
        out_valid  = 1'b1;
        ctrl.shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign word_index = emit_idx;
  assign last_word  = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (ctrl.step) begin
        step <= step_last ? '0 : step + 1'b1;
      end
      if (ctrl.shift) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

endmodule

/* sv/chacha20_block_keystream.sv */
// chacha20_block_keystream: ChaCha20 block function producing 16 keystream words per counter.
// Depends on cc20_pkg, cc20_if, cc20_cfg, cc20_lane, cc20_seq.
//
//   channel  dir  handshake     payload
//   ctr_ch   in   valid/ready   block_counter[31:0]
//   ks_ch    out  valid/ready   word_index[3:0], keystream_word[31:0], last_word
//   cfg      in   cfg_we        cfg_index[2:0], cfg_data[63:0]
//
// A block passes through the accept (ST_IDLE), DOUBLE_ROUNDS double rounds of round steps
// (ST_ROUND), the final add (ST_FINAL) and the output of its 16 words (ST_EMIT).
// The round time is set by the four shared quarter-round lanes, one add/xor/rotate
// line each per cycle. ctr_ch.ready is high only between blocks.
// rst is synchronous; it clears the configuration registers and the sequencer.
// ks_ch.ready low holds the current word until it is taken.
module chacha20_block_keystream #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]   cfg_data,
  cc20_ctr_if.sink                          ctr_ch,
  cc20_ks_if.source                         ks_ch
);
  import cc20_pkg::*;

  logic [CFG_WORDS-1:0][WORD_W-1:0] cfg_words;
  logic [WORD_W-1:0] init_words [NUM_WORDS];
  logic [WORD_W-1:0] w          [NUM_WORDS];
  logic [WORD_W-1:0] w_next     [NUM_WORDS];
  logic [WORD_W-1:0] qa [LANES];
  logic [WORD_W-1:0] qb [LANES];
  logic [WORD_W-1:0] qc [LANES];
  logic [WORD_W-1:0] qd [LANES];
  logic [WORD_W-1:0] held_counter;
  ctrl_t             ctrl;

  cc20_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_words (cfg_words)
  );

  cc20_seq #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ctr_ch.valid),
    .out_ready  (ks_ch.ready),
    .in_ready   (ctr_ch.ready),
    .out_valid  (ks_ch.valid),
    .word_index (ks_ch.word_index),
    .last_word  (ks_ch.last_word),
    .ctrl       (ctrl)
  );

  // lane j works on column j: rows 0..3 hold a, b, c, d
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    cc20_lane u_lane (
      .phase (ctrl.phase),
      .a     (w[j]),
      .b     (w[LANES + j]),
      .c     (w[2*LANES + j]),
      .d     (w[3*LANES + j]),
      .qa    (qa[j]),
      .qb    (qb[j]),
      .qc    (qc[j]),
      .qd    (qd[j])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (k < COUNTER_WORD) begin
        init_words[k] = cfg_words[k];
      end else if (k == COUNTER_WORD) begin
        init_words[k] = held_counter;
      end else begin
        init_words[k] = cfg_words[k-1];
      end
    end
  end

  // after the last line of a half round, rows 1..3 are rotated so the next
  // half round (diagonal or column) again sees its quarter-rounds as columns
  always_comb begin
    w_next = w;
    if (ctrl.load) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        w_next[k] = (k == COUNTER_WORD) ? ctr_ch.block_counter : init_words[k];
      end
    end else if (ctrl.step) begin
      for (int j = 0; j < LANES; j++) begin
        w_next[j] = qa[j];
        if (ctrl.phase != PH_C7) begin
          w_next[LANES + j]   = qb[j];
          w_next[2*LANES + j] = qc[j];
          w_next[3*LANES + j] = qd[j];
        end else if (!ctrl.diag) begin
          w_next[LANES + j]   = qb[(j + 1) % LANES];
          w_next[2*LANES + j] = qc[(j + 2) % LANES];
          w_next[3*LANES + j] = qd[(j + 3) % LANES];
        end else begin
          w_next[LANES + j]   = qb[(j + 3) % LANES];
          w_next[2*LANES + j] = qc[(j + 2) % LANES];
          w_next[3*LANES + j] = qd[(j + 1) % LANES];
        end
      end
    end else if (ctrl.finalize) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        w_next[k] = w[k] + init_words[k];
      end
    end else if (ctrl.shift) begin
      for (int k = 0; k < NUM_WORDS - 1; k++) begin
        w_next[k] = w[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_counter <= '0;
    end else if (ctrl.load) begin
      held_counter <= ctr_ch.block_counter;
    end
  end

  assign ks_ch.keystream_word = w[0];

  a_no_out_after_accept: assert property (@(posedge clk) disable iff (rst)
    (ctr_ch.valid && ctr_ch.ready) |=> !ks_ch.valid)
    else $error("result shown right after a counter was taken");

  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    ks_ch.valid |-> !ctr_ch.ready)
    else $error("counter channel ready while words are pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (ks_ch.valid && ks_ch.ready && ks_ch.last_word) |=> (ctr_ch.ready && !ks_ch.valid))
    else $error("block did not return to idle after its last word");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    (ks_ch.valid && ks_ch.ready && !ks_ch.last_word) |=>
      (ks_ch.valid && (ks_ch.word_index == WORD_IDX_W'($past(ks_ch.word_index) + 1'b1))))
    else $error("word index did not advance by one");

endmodule

/* tb/chacha20_block_keystream_tb.sv */
`timescale 1ns / 100ps
// chacha20_block_keystream_tb: self-checking bench for the ChaCha20 keystream block.
// Predicts all sixteen words per counter and checks them in order under random stalls.
// Depends on cc20_pkg, cc20_if and chacha20_block_keystream.
module chacha20_block_keystream_tb;
  import cc20_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_ALL [8] = '{
    REG_CONST_LOW, REG_CONST_HIGH, REG_KEY_0, REG_KEY_1,
    REG_KEY_2, REG_KEY_3, REG_NONCE_LOW, REG_NONCE_HIGH
  };

  typedef struct packed {
    logic [WORD_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]     keystream_word;
    logic                  last_word;
  } ks_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cc20_ctr_if ctr_ch();
  cc20_ks_if  ks_ch();

  chacha20_block_keystream dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctr_ch    (ctr_ch),
    .ks_ch     (ks_ch)
  );

  logic [CFG_DATA_W-1:0] cfg_shadow [8] = '{default: '0};
  logic [WORD_W-1:0]     mix_w [NUM_WORDS];
  ks_word_t              ks_expected [$];
  ks_word_t              ks_head;
  int                    mismatch_count = 0;
  bit                    idle_on = 1'b1;
  int                    hold_req = 0;
  bit                    hold_taken = 1'b0;
  int                    sink_hold = 0;
  int                    sink_stall = 0;
  int                    quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x, input int n);
    logic [2*WORD_W-1:0] twice;
    twice = {x, x} << n;
    return twice[2*WORD_W-1:WORD_W];
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], ROT_A16);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], ROT_C12);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rot_left(mix_w[d] ^ mix_w[a], ROT_A8);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rot_left(mix_w[b] ^ mix_w[c], ROT_C7);
  endfunction

  function automatic void predict_block(input logic [WORD_W-1:0] counter);
    logic [WORD_W-1:0] init_w [NUM_WORDS];
    int i;
    {init_w[1], init_w[0]}   = cfg_shadow[REG_CONST_LOW];
    {init_w[3], init_w[2]}   = cfg_shadow[REG_CONST_HIGH];
    {init_w[5], init_w[4]}   = cfg_shadow[REG_KEY_0];
    {init_w[7], init_w[6]}   = cfg_shadow[REG_KEY_1];
    {init_w[9], init_w[8]}   = cfg_shadow[REG_KEY_2];
    {init_w[11], init_w[10]} = cfg_shadow[REG_KEY_3];
    init_w[COUNTER_WORD]     = counter;
    {init_w[14], init_w[13]} = cfg_shadow[REG_NONCE_LOW];
    init_w[15]               = cfg_shadow[REG_NONCE_HIGH][WORD_W-1:0];
    mix_w = init_w;
    for (i = 0; i < DOUBLE_ROUNDS; i++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (i = 0; i < NUM_WORDS; i++) begin
      ks_expected.push_back('{word_index: i[WORD_IDX_W-1:0],
                              keystream_word: mix_w[i] + init_w[i],
                              last_word: (i == NUM_WORDS - 1)});
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // called at a rising edge; clears cfg_we after the write and returns with it low
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow[index] = (index == REG_NONCE_HIGH) ? {32'h0, data[WORD_W-1:0]} : data;
    @(posedge clk);
  endtask

  // called at a rising edge; returns at the edge the transaction is taken, valid left high
  task automatic send_counter(input logic [WORD_W-1:0] counter);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      ctr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ctr_ch.valid         <= 1'b1;
    ctr_ch.block_counter <= counter;
    @(posedge clk);
    while (!ctr_ch.ready) @(posedge clk);
    predict_block(counter);
  endtask

  task automatic wait_drained();
    ctr_ch.valid <= 1'b0;
    while (ks_expected.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // receiver: random stall bursts plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0 && !hold_taken) begin
      sink_hold = hold_req;
      hold_taken = 1'b1;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      ks_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      ks_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 5);
      ks_ch.ready <= 1'b0;
    end else begin
      ks_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && ks_ch.valid && ks_ch.ready) begin
      if (ks_expected.size() == 0) begin
        report_mismatch("unexpected keystream word", ks_ch.keystream_word, '0);
      end else begin
        ks_head = ks_expected.pop_front();
        if (ks_ch.word_index !== ks_head.word_index)
          report_mismatch("word_index", ks_ch.word_index, ks_head.word_index);
        if (ks_ch.keystream_word !== ks_head.keystream_word)
          report_mismatch("keystream_word", ks_ch.keystream_word, ks_head.keystream_word);
        if (ks_ch.last_word !== ks_head.last_word)
          report_mismatch("last_word", ks_ch.last_word, ks_head.last_word);
      end
    end
  end

  always @(posedge clk) begin
    if ((ctr_ch.valid && ctr_ch.ready) || (ks_ch.valid && ks_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("chacha20_block_keystream verification failed");
        $finish;
      end
    end
  end

  // all registers still zero from reset
  task automatic test_reset_defaults();
    send_counter(32'h0000_0000);
    send_counter(32'hFFFF_FFFF);
    send_counter(32'h0000_0001);
    wait_drained();
  endtask

  task automatic test_published_vector();
    write_reg(REG_CONST_LOW,  64'h3320646e_61707865);
    write_reg(REG_CONST_HIGH, 64'h6b206574_79622d32);
    write_reg(REG_KEY_0,      64'h07060504_03020100);
    write_reg(REG_KEY_1,      64'h0f0e0d0c_0b0a0908);
    write_reg(REG_KEY_2,      64'h17161514_13121110);
    write_reg(REG_KEY_3,      64'h1f1e1d1c_1b1a1918);
    write_reg(REG_NONCE_LOW,  64'h4a000000_09000000);
    write_reg(REG_NONCE_HIGH, 64'h0);
    send_counter(32'h0000_0001);
    send_counter(32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_extreme_values();
    // all ones, so adds wrap; nonce_high upper half must be dropped
    foreach (REG_ALL[r]) write_reg(REG_ALL[r], '1);
    send_counter(32'h0000_0000);
    send_counter(32'hFFFF_FFFF);
    wait_drained();
    foreach (REG_ALL[r]) write_reg(REG_ALL[r], {32{2'b10}});
    send_counter(32'h5555_5555);
    wait_drained();
    foreach (REG_ALL[r]) write_reg(REG_ALL[r], {32{2'b01}});
    send_counter(32'hAAAA_AAAA);
    wait_drained();
    write_reg(REG_NONCE_HIGH, 64'hFFFF_FFFF_0000_0001);
    send_counter(32'h8000_0000);
    wait_drained();
  endtask

  // mostly incrementing counters, as in a real stream, with jumps and wrap points
  task automatic test_random_phases();
    logic [WORD_W-1:0]     counter;
    logic [CFG_DATA_W-1:0] value;
    int                    roll;
    int                    phase;
    for (phase = 0; phase < 8; phase++) begin
      foreach (REG_ALL[r]) begin
        if (phase == 0 || $urandom_range(0, 3) != 0) begin
          roll = $urandom_range(0, 7);
          value = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
          write_reg(REG_ALL[r], value);
        end
      end
      counter = $urandom;
      repeat (45) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) counter = $urandom;
        else if (roll == 1) counter = $urandom_range(0, 2);
        else if (roll == 2) counter = 32'hFFFF_FFFF - $urandom_range(0, 2);
        else counter = counter + 1;
        send_counter(counter);
      end
      wait_drained();
    end
  endtask

  task automatic test_sink_holdoff();
    @(negedge clk) hold_req = HOLDOFF_CYCLES;
    @(posedge clk);
    repeat (4) send_counter($urandom);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    @(negedge clk) idle_on = 1'b0;
    @(posedge clk);
    repeat (40) send_counter($urandom);
    wait_drained();
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_CONST_LOW;
    cfg_data             <= '0;
    ctr_ch.valid         <= 1'b0;
    ctr_ch.block_counter <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_published_vector();
    test_extreme_values();
    test_random_phases();
    test_sink_holdoff();
    test_back_to_back();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && ks_expected.size() == 0) begin
      $display("chacha20_block_keystream verification clean");
    end else begin
      $display("chacha20_block_keystream verification failed");
    end
    $finish;
  end

endmodule
